// File: rtl/sound_latch_and_psg_bus_bridge_top_macros.svh
// Assertion macros for the sound latch / PSG bridge.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef SOUND_LATCH_AND_PSG_BUS_BRIDGE_TOP_MACROS_SVH
`define SOUND_LATCH_AND_PSG_BUS_BRIDGE_TOP_MACROS_SVH

// same-cycle implication
`define SLPSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLPSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/slpsg_pkg.sv
// Package for the sound latch / PSG bus bridge: beat types, codes, constants.
// No dependencies.
package slpsg_pkg;

  typedef enum logic [2:0] {
    CMD_MAIN_WRITE = 3'd0,
    CMD_SOUND_ACK  = 3'd1,
    CMD_LATCH_READ = 3'd2,
    CMD_PORT_WRITE = 3'd3,
    CMD_PORT_READ  = 3'd4
  } cmd_e;

  localparam logic [7:0] PORT_DATA    = 8'h01;
  localparam logic [7:0] PORT_CONTROL = 8'h02;

  // control port bits
  localparam int CTL_STROBE_BIT = 0;
  localparam int CTL_ADDR_BIT   = 2;
  localparam int CTL_CHIP0_BIT  = 3;
  localparam int CTL_CHIP1_BIT  = 4;

  localparam int CMD_HI_BIT     = 7;
  localparam logic [3:0] MIRROR_LIMIT = 4'd14;
  localparam logic [3:0] LATCH_REG    = 4'd14;
  localparam logic [7:0] UNMAPPED     = 8'hFF;

  localparam int REG_W     = 8;
  localparam int CHIP_REGS = 16;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] port_number;
    logic [7:0] write_value;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       mirror_valid;
    logic [4:0] mirror_index;
    logic [7:0] mirror_value;
    logic       handshake_set;
  } out_t;

  // beat waiting on the register file read
  typedef struct packed {
    out_t res;
    logic from_mem;
    logic chip_sel;
    logic entry_valid;
  } rd_stage_t;

endpackage

// File: rtl/slpsg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module slpsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/sound_latch_and_psg_bus_bridge_top.sv
// Sound latch / PSG bus bridge: command latch, IRQ, port latches, two chip reg files.
// Depends on slpsg_pkg, slpsg_ram and the assertion macro header.
// Stages: register file read, then output register. Throughput: 1 beat per cycle
// unless out_ready stalls; each chip's register file has one write and one read port.
// Reset (rst_n low, synchronous): latches and chip addresses to zero, IRQ asserted,
// register file entries marked unwritten (they read as zero), pipeline emptied.
`include "sound_latch_and_psg_bus_bridge_top_macros.svh"

module sound_latch_and_psg_bus_bridge_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  slpsg_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output slpsg_pkg::out_t  out_data
);

  localparam int AW = $clog2(slpsg_pkg::CHIP_REGS);

  // architectural state
  logic [7:0]                       latch_r, latch_nxt;
  logic                             irq_r, irq_nxt;
  logic [7:0]                       data_r, data_nxt;
  logic [7:0]                       ctl_r, ctl_nxt;
  logic [AW-1:0]                    addr0_r, addr0_nxt;
  logic [AW-1:0]                    addr1_r, addr1_nxt;
  logic [slpsg_pkg::CHIP_REGS-1:0]  val0_r, val0_nxt;
  logic [slpsg_pkg::CHIP_REGS-1:0]  val1_r, val1_nxt;

  // pipeline
  logic                   s1_v_r;
  slpsg_pkg::rd_stage_t   s1_r, s1_nxt;
  logic                   out_v_r;
  slpsg_pkg::out_t        out_r, s1_res;

  logic accept, s1_move;
  logic we0, we1, re0, re1;
  logic [slpsg_pkg::REG_W-1:0] q0, q1;

  assign s1_move  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || !out_v_r || out_ready;
  assign accept   = in_valid && in_ready;

  // bus access decode, working on the state as it stands before this beat
  always_comb begin
    logic strobe_fall;
    strobe_fall = 1'b0;
    latch_nxt = latch_r;
    irq_nxt   = irq_r;
    data_nxt  = data_r;
    ctl_nxt   = ctl_r;
    addr0_nxt = addr0_r;
    addr1_nxt = addr1_r;
    val0_nxt  = val0_r;
    val1_nxt  = val1_r;
    we0 = 1'b0;
    we1 = 1'b0;
    re0 = 1'b0;
    re1 = 1'b0;
    s1_nxt = '0;

    case (slpsg_pkg::cmd_e'(in_data.cmd))
      slpsg_pkg::CMD_MAIN_WRITE: begin
        latch_nxt = in_data.write_value;
        if (!in_data.write_value[slpsg_pkg::CMD_HI_BIT]) begin
          irq_nxt = 1'b1;
        end
      end
      slpsg_pkg::CMD_SOUND_ACK: begin
        if (latch_r[slpsg_pkg::CMD_HI_BIT]) begin
          irq_nxt = 1'b0;
        end
      end
      slpsg_pkg::CMD_LATCH_READ: begin
        s1_nxt.res.read_data = latch_r;
      end
      slpsg_pkg::CMD_PORT_WRITE: begin
        if (in_data.port_number == slpsg_pkg::PORT_DATA) begin
          data_nxt = in_data.write_value;
        end else if (in_data.port_number == slpsg_pkg::PORT_CONTROL) begin
          ctl_nxt = in_data.write_value;
          strobe_fall = ctl_r[slpsg_pkg::CTL_STROBE_BIT] &&
                        !in_data.write_value[slpsg_pkg::CTL_STROBE_BIT];
        end
      end
      slpsg_pkg::CMD_PORT_READ: begin
        if (in_data.port_number == slpsg_pkg::PORT_DATA) begin
          if (ctl_r[slpsg_pkg::CTL_CHIP0_BIT]) begin
            if (addr0_r == slpsg_pkg::LATCH_REG) begin
              s1_nxt.res.read_data = latch_r;
            end else begin
              re0 = 1'b1;
              s1_nxt.from_mem    = 1'b1;
              s1_nxt.chip_sel    = 1'b0;
              s1_nxt.entry_valid = val0_r[addr0_r];
            end
          end else if (ctl_r[slpsg_pkg::CTL_CHIP1_BIT]) begin
            re1 = 1'b1;
            s1_nxt.from_mem    = 1'b1;
            s1_nxt.chip_sel    = 1'b1;
            s1_nxt.entry_valid = val1_r[addr1_r];
          end else begin
            s1_nxt.res.read_data = slpsg_pkg::UNMAPPED;
          end
        end else if (in_data.port_number != slpsg_pkg::PORT_CONTROL) begin
          s1_nxt.res.read_data = slpsg_pkg::UNMAPPED;
        end
      end
      default: begin
      end
    endcase

    // bus cycle on the strobe falling edge, steered by the old control bits
    if (strobe_fall) begin
      s1_nxt.res.handshake_set = 1'b1;
      if (ctl_r[slpsg_pkg::CTL_ADDR_BIT]) begin
        if (ctl_r[slpsg_pkg::CTL_CHIP0_BIT]) addr0_nxt = data_r[AW-1:0];
        if (ctl_r[slpsg_pkg::CTL_CHIP1_BIT]) addr1_nxt = data_r[AW-1:0];
      end else begin
        if (ctl_r[slpsg_pkg::CTL_CHIP0_BIT]) begin
          we0 = 1'b1;
          val0_nxt[addr0_r] = 1'b1;
        end
        if (ctl_r[slpsg_pkg::CTL_CHIP1_BIT]) begin
          we1 = 1'b1;
          val1_nxt[addr1_r] = 1'b1;
        end
        // only one mirrored write fits in a beat; chip 0 has priority
        if (we0 && addr0_r < slpsg_pkg::MIRROR_LIMIT) begin
          s1_nxt.res.mirror_valid = 1'b1;
          s1_nxt.res.mirror_index = {1'b0, addr0_r};
          s1_nxt.res.mirror_value = data_r;
        end else if (we1 && addr1_r < slpsg_pkg::MIRROR_LIMIT) begin
          s1_nxt.res.mirror_valid = 1'b1;
          s1_nxt.res.mirror_index = {1'b1, addr1_r};
          s1_nxt.res.mirror_value = data_r;
        end
      end
    end

    s1_nxt.res.irq_line = irq_nxt;
  end

  slpsg_ram #(.WIDTH(slpsg_pkg::REG_W), .DEPTH(slpsg_pkg::CHIP_REGS)) u_chip0_regs (
    .clk   (clk),
    .we    (accept && we0),
    .waddr (addr0_r),
    .wdata (data_r),
    .re    (accept && re0),
    .raddr (addr0_r),
    .rdata (q0)
  );

  slpsg_ram #(.WIDTH(slpsg_pkg::REG_W), .DEPTH(slpsg_pkg::CHIP_REGS)) u_chip1_regs (
    .clk   (clk),
    .we    (accept && we1),
    .waddr (addr1_r),
    .wdata (data_r),
    .re    (accept && re1),
    .raddr (addr1_r),
    .rdata (q1)
  );

  // merge register file data into the read stage result
  always_comb begin
    s1_res = s1_r.res;
    if (s1_r.from_mem) begin
      if (!s1_r.entry_valid) begin
        s1_res.read_data = '0;
      end else if (s1_r.chip_sel) begin
        s1_res.read_data = q1;
      end else begin
        s1_res.read_data = q0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
      irq_r   <= 1'b1;
      data_r  <= '0;
      ctl_r   <= '0;
      addr0_r <= '0;
      addr1_r <= '0;
      val0_r  <= '0;
      val1_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        latch_r <= latch_nxt;
        irq_r   <= irq_nxt;
        data_r  <= data_nxt;
        ctl_r   <= ctl_nxt;
        addr0_r <= addr0_nxt;
        addr1_r <= addr1_nxt;
        val0_r  <= val0_nxt;
        val1_r  <= val1_nxt;
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
    if (s1_move) begin
      out_r <= s1_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `SLPSG_ASSERT_NEXT(a_irq_on_cmd, accept && in_data.cmd == slpsg_pkg::CMD_MAIN_WRITE && !in_data.write_value[slpsg_pkg::CMD_HI_BIT], irq_r, "IRQ not raised by command write")
  `SLPSG_ASSERT_NOW(a_mirror_has_strobe, s1_v_r && s1_r.res.mirror_valid, s1_r.res.handshake_set, "mirrored write without strobe")
  `SLPSG_ASSERT_NOW(a_mem_read_no_strobe, s1_v_r && s1_r.from_mem, !s1_r.res.handshake_set && !s1_r.res.mirror_valid, "register read flagged as write")

endmodule

// File: dv/sound_latch_and_psg_bus_bridge_top_tb.sv
// Self-checking bench for the sound latch / PSG bus bridge: directed and random bus beats.
// Depends on slpsg_pkg and sound_latch_and_psg_bus_bridge_top; predicts each result in-bench.
`timescale 1ns / 100ps

module sound_latch_and_psg_bus_bridge_top_tb;
  import slpsg_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_BEATS = 1900;
  localparam int unsigned LONG_HOLD    = 300;

  // cmd values the block leaves undefined
  localparam logic [2:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [2:0] CMD_RSVD_LAST  = 3'd7;

  localparam logic [7:0] CTL_STB   = 8'h01 << CTL_STROBE_BIT;
  localparam logic [7:0] CTL_ADDR  = 8'h01 << CTL_ADDR_BIT;
  localparam logic [7:0] CTL_C0    = 8'h01 << CTL_CHIP0_BIT;
  localparam logic [7:0] CTL_C1    = 8'h01 << CTL_CHIP1_BIT;
  localparam logic [7:0] CTL_SPARE = ~(CTL_STB | CTL_ADDR | CTL_C0 | CTL_C1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sound_latch_and_psg_bus_bridge_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bridge state as the bench sees it
  logic [7:0] snd_latch;
  logic       irq_level;
  logic [7:0] data_byte;
  logic [7:0] ctl_byte;
  logic [3:0] psg_addr [2];
  logic [7:0] psg_regs [32];

  in_t  pending_beats [$];
  out_t expected_results [$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_queued = 0;
  int unsigned beats_in = 0;
  logic        in_taken = 1'b0;

  task automatic report_mismatch(string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  function automatic logic [7:0] psg_read();
    if (ctl_byte[CTL_CHIP0_BIT]) begin
      if (psg_addr[0] == LATCH_REG) return snd_latch;
      return psg_regs[psg_addr[0]];
    end
    if (ctl_byte[CTL_CHIP1_BIT]) return psg_regs[16 + psg_addr[1]];
    return UNMAPPED;
  endfunction

  function automatic out_t bridge_step(in_t b);
    out_t r;
    logic [7:0] old_ctl;
    logic [3:0] rsel;
    int sel_bit;
    r = '0;
    case (b.cmd)
      CMD_MAIN_WRITE: begin
        snd_latch = b.write_value;
        if (!b.write_value[CMD_HI_BIT]) irq_level = 1'b1;
      end
      CMD_SOUND_ACK: begin
        if (snd_latch[CMD_HI_BIT]) irq_level = 1'b0;
      end
      CMD_LATCH_READ: r.read_data = snd_latch;
      CMD_PORT_WRITE: begin
        if (b.port_number == PORT_DATA) begin
          data_byte = b.write_value;
        end else if (b.port_number == PORT_CONTROL) begin
          old_ctl = ctl_byte;
          // bus cycle on strobe falling edge, decoded from the old control bits
          if (old_ctl[CTL_STROBE_BIT] && !b.write_value[CTL_STROBE_BIT]) begin
            if (old_ctl[CTL_ADDR_BIT]) begin
              if (old_ctl[CTL_CHIP0_BIT]) psg_addr[0] = data_byte[3:0];
              if (old_ctl[CTL_CHIP1_BIT]) psg_addr[1] = data_byte[3:0];
            end else begin
              for (int c = 0; c < 2; c++) begin
                sel_bit = c ? CTL_CHIP1_BIT : CTL_CHIP0_BIT;
                if (old_ctl[sel_bit]) begin
                  rsel = psg_addr[c];
                  psg_regs[c * 16 + rsel] = data_byte;
                  // only the first qualifying chip is reported
                  if (rsel < MIRROR_LIMIT && !r.mirror_valid) begin
                    r.mirror_valid = 1'b1;
                    r.mirror_index = 5'(c * 16 + rsel);
                    r.mirror_value = data_byte;
                  end
                end
              end
            end
            r.handshake_set = 1'b1;
          end
          ctl_byte = b.write_value;
        end
      end
      CMD_PORT_READ: begin
        if (b.port_number == PORT_DATA) r.read_data = psg_read();
        else if (b.port_number == PORT_CONTROL) r.read_data = 8'h00;
        else r.read_data = UNMAPPED;
      end
      default: ;
    endcase
    r.irq_line = irq_level;
    return r;
  endfunction

  // input and result side, both sampled at the rising edge
  always @(posedge clk) begin
    out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", out_data.read_data, want.read_data);
          check_field("irq_line", 8'(out_data.irq_line), 8'(want.irq_line));
          check_field("mirror_valid", 8'(out_data.mirror_valid), 8'(want.mirror_valid));
          check_field("mirror_index", 8'(out_data.mirror_index), 8'(want.mirror_index));
          check_field("mirror_value", out_data.mirror_value, want.mirror_value);
          check_field("handshake_set", 8'(out_data.handshake_set), 8'(want.handshake_set));
        end
      end
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(bridge_step(in_data));
        beats_in <= beats_in + 1;
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // sender: bursts with random gaps
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (gap_left != 0 || pending_beats.size() == 0) begin
        if (gap_left != 0) gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // receiver: changing stall pattern plus one long hold-off
  int unsigned hold_cnt = 0;
  logic        long_hold_done = 1'b0;
  int unsigned mode_left = 0;
  int unsigned stall_mode = 0;
  int unsigned tick = 0;

  always @(negedge clk) begin
    tick <= tick + 1;
    if (!long_hold_done && beats_in >= 400) begin
      long_hold_done <= 1'b1;
      hold_cnt <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (mode_left == 0) begin
      mode_left  <= $urandom_range(32, 256);
      stall_mode <= $urandom_range(0, 3);
      out_ready  <= 1'b1;
    end else begin
      mode_left <= mode_left - 1;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= (tick % 4 == 0);
        default: out_ready <= (tick % 7 != 3);
      endcase
    end
  end

  function automatic void push_beat(logic [2:0] c, logic [7:0] p, logic [7:0] v);
    in_t b;
    b.cmd = c;
    b.port_number = p;
    b.write_value = v;
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] chip_sel_bits();
    int unsigned m;
    logic [7:0] s;
    m = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
    s = 8'h00;
    if (m[0]) s |= CTL_C0;
    if (m[1]) s |= CTL_C1;
    return s;
  endfunction

  // data latch, strobe high, strobe low; optionally read back the selected reg
  function automatic void bus_cycle(logic addr_mode, logic [7:0] sel);
    logic [7:0] v;
    v = rnd_byte();
    if (addr_mode && $urandom_range(0, 3) != 0) v[3:0] = 4'($urandom_range(12, 15));
    push_beat(CMD_PORT_WRITE, PORT_DATA, v);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL,
              CTL_STB | (addr_mode ? CTL_ADDR : 8'h00) | sel | (rnd_byte() & CTL_SPARE));
    push_beat(CMD_PORT_WRITE, PORT_CONTROL,
              (($urandom_range(0, 1) != 0) ? sel : chip_sel_bits()) |
              (rnd_byte() & (CTL_SPARE | CTL_ADDR)));
    if ($urandom_range(0, 1) != 0) push_beat(CMD_PORT_READ, PORT_DATA, rnd_byte());
  endfunction

  function automatic void random_seq();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) bus_cycle(1'b1, chip_sel_bits());
    else if (pick < 76) bus_cycle(1'b0, chip_sel_bits());
    else if (pick < 82) push_beat(CMD_PORT_READ, PORT_DATA, rnd_byte());
    else if (pick < 92) begin
      case ($urandom_range(0, 2))
        0: push_beat(CMD_MAIN_WRITE, rnd_byte(), rnd_byte());
        1: push_beat(CMD_SOUND_ACK, rnd_byte(), rnd_byte());
        default: push_beat(CMD_LATCH_READ, rnd_byte(), rnd_byte());
      endcase
    end else begin
      push_beat(3'($urandom_range(0, 7)), rnd_byte(), rnd_byte());
    end
  endfunction

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    snd_latch = 8'h00;
    irq_level = 1'b1;
    data_byte = 8'h00;
    ctl_byte  = 8'h00;
    psg_addr[0] = 4'h0;
    psg_addr[1] = 4'h0;
    for (int i = 0; i < 32; i++) psg_regs[i] = 8'h00;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: IRQ rules, latch readback, address 14, both chips, unmapped ports
    push_beat(CMD_LATCH_READ, 8'h00, 8'h00);
    push_beat(CMD_SOUND_ACK, 8'h00, 8'hFF);
    push_beat(CMD_MAIN_WRITE, 8'hFF, 8'h80);
    push_beat(CMD_SOUND_ACK, 8'h00, 8'h00);
    push_beat(CMD_LATCH_READ, 8'h00, 8'h00);
    push_beat(CMD_MAIN_WRITE, 8'h00, 8'h7F);
    push_beat(CMD_PORT_WRITE, PORT_DATA, 8'h0E);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, CTL_STB | CTL_ADDR | CTL_C0 | CTL_C1);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, CTL_C0);
    push_beat(CMD_PORT_WRITE, PORT_DATA, 8'hA5);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, CTL_STB | CTL_C0 | CTL_C1);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, CTL_C0 | CTL_C1);
    push_beat(CMD_PORT_READ, PORT_DATA, 8'h00);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, 8'h00);
    push_beat(CMD_PORT_READ, PORT_DATA, 8'h00);
    push_beat(CMD_PORT_READ, PORT_CONTROL, 8'h00);
    push_beat(CMD_PORT_READ, 8'hFF, 8'hFF);
    push_beat(CMD_RSVD_LAST, PORT_DATA, 8'hFF);
    push_beat(CMD_RSVD_FIRST, PORT_CONTROL, 8'h00);
    push_beat(CMD_PORT_WRITE, 8'hFF, 8'hFF);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, CTL_STB);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, 8'h00);
    push_beat(CMD_PORT_WRITE, PORT_DATA, 8'h3D);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, 8'hFF);
    push_beat(CMD_PORT_WRITE, PORT_CONTROL, 8'h00);
    wait_idle();

    while (beats_queued < 25 + RANDOM_BEATS / 2) random_seq();
    // sender pause: let everything drain before the second half
    wait_idle();
    while (beats_queued < 25 + RANDOM_BEATS) random_seq();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) report_mismatch("results still expected at end");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
